// ===== sv/sth_pkg.sv =====
// ----------------------------------------------------------------------------
// sth_pkg: shared types and constants of the state transition histogram
// Field widths of the channels and the command and status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package sth_pkg;

  localparam int SLOT_IN_W = 8;   // width of slot_index on the input channel
  localparam int CODE_W    = 4;   // width of a state code
  localparam int RES_W     = 32;  // width of every reported count

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;  // write reset contents at the clear pointer, then advance it
    logic capture;   // take the input transaction, start slot and occupancy reads
    logic pair_rd;   // start the pair counter read
    logic update;    // write back counters and load the output register
  } sth_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // clear pointer is at the last memory entry
    logic out_free;  // output register is empty or is drained this cycle
  } sth_sts_t;

endpackage

// ===== sv/sth_if.sv =====
// ----------------------------------------------------------------------------
// sth_in_if / sth_out_if: channels of the state transition histogram
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface sth_in_if import sth_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [SLOT_IN_W-1:0] slot_index;
  logic [CODE_W-1:0]    state_code;

  modport source (output valid, slot_index, state_code, input ready);
  modport sink   (input valid, slot_index, state_code, output ready);
endinterface

interface sth_out_if import sth_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [SLOT_IN_W-1:0] slot_echo;
  logic [RES_W-1:0]     observed_total;
  logic [RES_W-1:0]     occupancy_of_code;
  logic [RES_W-1:0]     transition_total;
  logic [RES_W-1:0]     pair_count;
  logic                 transition_seen;
  logic [CODE_W-1:0]    dominant_code;
  logic                 saturated;

  modport source (output valid, slot_echo, observed_total, occupancy_of_code,
                  transition_total, pair_count, transition_seen, dominant_code,
                  saturated, input ready);
  modport sink   (input valid, slot_echo, observed_total, occupancy_of_code,
                  transition_total, pair_count, transition_seen, dominant_code,
                  saturated, output ready);
endinterface

// ===== sv/state_transition_histogram.sv =====
// ----------------------------------------------------------------------------
// state_transition_histogram: per-slot state occupancy and transition counter
// Top level joining the sequencer and the counting datapath.
// ----------------------------------------------------------------------------
// Each input transaction is one observation (slot, state code) and yields one
// result transaction. After reset the block runs a clearing pass over every
// entry of the record, occupancy and pair counter memories, during which
// in_if.ready stays low. After that an observation is handled in steps: the
// slot record and occupancy counter are read, the pair counter read follows
// once the previous code is known, then all counters are written back and
// the result is registered. The next observation is taken while a result
// still waits in the output register; a result that is not taken holds the
// block in its write-back state.
module state_transition_histogram import sth_pkg::*; #(
  parameter int MAX_SLOTS   = 256,
  parameter int NUM_CODES   = 8,
  parameter int COUNT_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  sth_in_if.sink    in_if,
  sth_out_if.source out_if
);

  sth_cmd_t cmd;
  sth_sts_t sts;

  sth_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  sth_dp #(
    .MAX_SLOTS   (MAX_SLOTS),
    .NUM_CODES   (NUM_CODES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_slot   (in_if.slot_index),
    .in_code   (in_if.state_code),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_slot  (out_if.slot_echo),
    .out_obs   (out_if.observed_total),
    .out_occ   (out_if.occupancy_of_code),
    .out_trn   (out_if.transition_total),
    .out_pair  (out_if.pair_count),
    .out_trans (out_if.transition_seen),
    .out_dom   (out_if.dominant_code),
    .out_sat   (out_if.saturated)
  );

endmodule

// ===== sv/sth_ram.sv =====
// ----------------------------------------------------------------------------
// sth_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sth_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/sth_ctrl.sv =====
// ----------------------------------------------------------------------------
// sth_ctrl: sequencer of the state transition histogram
// Runs the clearing pass after reset, then walks each transaction through
// fetch and update.
// ----------------------------------------------------------------------------
module sth_ctrl import sth_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output sth_cmd_t cmd,
  input  sth_sts_t sts
);

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_FETCH  = 2'd2;
  localparam logic [1:0] S_UPDATE = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_FETCH;
        end
      end
      S_FETCH: begin
        // The pair counter address needs the previous code read last cycle.
        cmd.pair_rd = 1'b1;
        state_nxt   = S_UPDATE;
      end
      S_UPDATE: begin
        if (sts.out_free) begin
          cmd.update = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/sth_dp.sv =====
// ----------------------------------------------------------------------------
// sth_dp: datapath of the state transition histogram
// Per-slot record, occupancy and pair counter memories, saturating update,
// running dominant code and the output register.
// ----------------------------------------------------------------------------
module sth_dp import sth_pkg::*; #(
  parameter int MAX_SLOTS   = 256,
  parameter int NUM_CODES   = 8,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sth_cmd_t               cmd,
  output sth_sts_t               sts,
  input  logic [SLOT_IN_W-1:0]   in_slot,
  input  logic [CODE_W-1:0]      in_code,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SLOT_IN_W-1:0]   out_slot,
  output logic [RES_W-1:0]       out_obs,
  output logic [RES_W-1:0]       out_occ,
  output logic [RES_W-1:0]       out_trn,
  output logic [RES_W-1:0]       out_pair,
  output logic                   out_trans,
  output logic [CODE_W-1:0]      out_dom,
  output logic                   out_sat
);

  localparam int SLOT_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CODE_B  = $clog2(NUM_CODES);
  localparam int OCC_AW  = SLOT_W + CODE_B;
  localparam int PAIR_AW = SLOT_W + 2 * CODE_B;
  localparam int REC_W   = 2 * CODE_W + 3 * COUNT_WIDTH;

  localparam logic [CODE_W-1:0]      NONE    = CODE_W'(NUM_CODES);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  // Transaction registers.
  logic [SLOT_IN_W-1:0] slot_r;
  logic [CODE_W-1:0]    code_r;
  logic                 in_range_r;
  logic [PAIR_AW-1:0]   clr_r;
  logic [PAIR_AW-1:0]   clr_nxt;

  // Output register, full counter width inside.
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [SLOT_IN_W-1:0]   out_slot_r;
  logic [COUNT_WIDTH-1:0] out_obs_r;
  logic [COUNT_WIDTH-1:0] out_occ_r;
  logic [COUNT_WIDTH-1:0] out_trn_r;
  logic [COUNT_WIDTH-1:0] out_pair_r;
  logic                   out_trans_r;
  logic [CODE_W-1:0]      out_dom_r;
  logic                   out_sat_r;

  // Memory ports.
  logic                   rec_we;
  logic [SLOT_W-1:0]      rec_wa;
  logic [REC_W-1:0]       rec_wd;
  logic [REC_W-1:0]       rec_rd;
  logic                   occ_we;
  logic [OCC_AW-1:0]      occ_wa;
  logic [COUNT_WIDTH-1:0] occ_wd;
  logic [COUNT_WIDTH-1:0] occ_rd;
  logic                   pair_we;
  logic [PAIR_AW-1:0]     pair_wa;
  logic [COUNT_WIDTH-1:0] pair_wd;
  logic [COUNT_WIDTH-1:0] pair_rd;

  logic [SLOT_W-1:0]      in_slot_a;
  logic [SLOT_W-1:0]      slot_a;
  logic [OCC_AW-1:0]      occ_ra;
  logic [PAIR_AW-1:0]     pair_ra;

  // Fields of the slot record.
  logic [CODE_W-1:0]      prev_q;
  logic [CODE_W-1:0]      dom_q;
  logic [COUNT_WIDTH-1:0] best_q;
  logic [COUNT_WIDTH-1:0] obs_q;
  logic [COUNT_WIDTH-1:0] trn_q;

  logic                   observed;
  logic                   trans;
  logic                   occ_sat, obs_sat, trn_sat, pair_sat;
  logic [COUNT_WIDTH-1:0] occ_new, obs_new, trn_new, pair_new;
  logic [CODE_W-1:0]      prev_n;
  logic [CODE_W-1:0]      dom_n;
  logic [COUNT_WIDTH-1:0] best_n;
  logic [COUNT_WIDTH-1:0] obs_n;
  logic [COUNT_WIDTH-1:0] trn_n;

  assign in_slot_a = SLOT_W'(in_slot);
  assign slot_a    = SLOT_W'(slot_r);
  assign occ_ra    = {in_slot_a, in_code[CODE_B-1:0]};

  assign {prev_q, dom_q, best_q, obs_q, trn_q} = rec_rd;
  assign pair_ra = {slot_a, prev_q[CODE_B-1:0], code_r[CODE_B-1:0]};

  assign observed = (code_r < NONE);
  assign trans    = observed && (prev_q < NONE) && (prev_q != code_r);

  // Saturating increments.
  assign occ_sat  = (occ_rd == CNT_MAX);
  assign obs_sat  = (obs_q == CNT_MAX);
  assign trn_sat  = (trn_q == CNT_MAX);
  assign pair_sat = (pair_rd == CNT_MAX);
  assign occ_new  = occ_sat  ? occ_rd  : occ_rd + CNT_ONE;
  assign obs_new  = obs_sat  ? obs_q   : obs_q + CNT_ONE;
  assign trn_new  = trn_sat  ? trn_q   : trn_q + CNT_ONE;
  assign pair_new = pair_sat ? pair_rd : pair_rd + CNT_ONE;

  // Occupancies only ever grow by one, so the dominant code can be kept
  // incrementally: the code just counted takes over when it passes the
  // current best, or ties it with a lower code.
  always_comb begin
    dom_n  = dom_q;
    best_n = best_q;
    if (observed) begin
      priority if (code_r == dom_q) begin
        best_n = occ_new;
      end else if ((occ_new > best_q) || ((occ_new == best_q) && (code_r < dom_q))) begin
        dom_n  = code_r;
        best_n = occ_new;
      end else begin
        dom_n  = dom_q;
        best_n = best_q;
      end
    end
  end

  assign prev_n = observed ? code_r : NONE;
  assign obs_n  = observed ? obs_new : obs_q;
  assign trn_n  = trans ? trn_new : trn_q;

  // Write ports: the clearing pass sweeps all three memories from one pointer.
  always_comb begin
    if (cmd.clr_step) begin
      rec_we  = 1'b1;
      rec_wa  = clr_r[SLOT_W-1:0];
      rec_wd  = {NONE, NONE, {(3 * COUNT_WIDTH){1'b0}}};
      occ_we  = 1'b1;
      occ_wa  = clr_r[OCC_AW-1:0];
      occ_wd  = '0;
      pair_we = 1'b1;
      pair_wa = clr_r;
      pair_wd = '0;
    end else begin
      rec_we  = cmd.update && in_range_r;
      rec_wa  = slot_a;
      rec_wd  = {prev_n, dom_n, best_n, obs_n, trn_n};
      occ_we  = cmd.update && in_range_r && observed;
      occ_wa  = {slot_a, code_r[CODE_B-1:0]};
      occ_wd  = occ_new;
      pair_we = cmd.update && in_range_r && trans;
      pair_wa = pair_ra;
      pair_wd = pair_new;
    end
  end

  sth_ram #(.WIDTH(REC_W), .DEPTH(1 << SLOT_W)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_wa),
    .wdata (rec_wd),
    .re    (cmd.capture),
    .raddr (in_slot_a),
    .rdata (rec_rd)
  );

  sth_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(1 << OCC_AW)) u_occ_ram (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_wa),
    .wdata (occ_wd),
    .re    (cmd.capture),
    .raddr (occ_ra),
    .rdata (occ_rd)
  );

  sth_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(1 << PAIR_AW)) u_pair_ram (
    .clk   (clk),
    .we    (pair_we),
    .waddr (pair_wa),
    .wdata (pair_wd),
    .re    (cmd.pair_rd),
    .raddr (pair_ra),
    .rdata (pair_rd)
  );

  assign clr_nxt      = cmd.clr_step ? clr_r + PAIR_AW'(1) : clr_r;
  assign sts.clr_last = (clr_r == {PAIR_AW{1'b1}});
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid_nxt = cmd.update ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      slot_r     <= in_slot;
      code_r     <= in_code;
      in_range_r <= (32'(in_slot) < 32'(MAX_SLOTS));
    end
    if (cmd.update) begin
      out_slot_r <= slot_r;
      if (in_range_r) begin
        out_obs_r   <= obs_n;
        out_occ_r   <= observed ? occ_new : '0;
        out_trn_r   <= trn_n;
        out_pair_r  <= trans ? pair_new : '0;
        out_trans_r <= trans;
        out_dom_r   <= dom_n;
        out_sat_r   <= observed && (occ_sat || obs_sat || (trans && (trn_sat || pair_sat)));
      end else begin
        out_obs_r   <= '0;
        out_occ_r   <= '0;
        out_trn_r   <= '0;
        out_pair_r  <= '0;
        out_trans_r <= 1'b0;
        out_dom_r   <= NONE;
        out_sat_r   <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_slot  = out_slot_r;
  assign out_obs   = RES_W'(out_obs_r);
  assign out_occ   = RES_W'(out_occ_r);
  assign out_trn   = RES_W'(out_trn_r);
  assign out_pair  = RES_W'(out_pair_r);
  assign out_trans = out_trans_r;
  assign out_dom   = out_dom_r;
  assign out_sat   = out_sat_r;

  // A result that reports no dominant code has no observations.
  a_dom_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_dom_r == NONE) |-> (out_obs_r == '0))
    else $error("dominant code unassigned while slot has observations");

  // Every occupancy and transition count is bounded by the observed count.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_occ_r <= out_obs_r) && (out_trn_r <= out_obs_r))
    else $error("occupancy or transition count exceeds observed count");

  // A counted transition leaves a nonzero pair count within the slot total.
  a_pair_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_trans_r |-> (out_pair_r != '0) && (out_pair_r <= out_trn_r))
    else $error("pair count inconsistent with transition total");

  // Memories are only written back once the output register can take the result.
  a_update_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> !out_valid_r || out_ready)
    else $error("result overwrote an undelivered transaction");

endmodule

// ===== verif/tb_state_transition_histogram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_state_transition_histogram: self-checking bench of the state histogram
// A table of directed observations, then random streams over a few busy slots,
// drive the input channel with random gaps. Every result transaction is
// compared field by field against a behavioral model of the per-slot counters.
// ----------------------------------------------------------------------------
module tb_state_transition_histogram import sth_pkg::*; ();

  localparam int                SLOT_COUNT   = 256;
  localparam int                NUM_CODES    = 8;
  localparam logic [CODE_W-1:0] CODE_UNOBS   = 4'd8;   // unobserved or no source
  localparam logic [CODE_W-1:0] CODE_RAW_TOP = 4'd15;  // highest raw code value
  localparam logic [RES_W-1:0]  COUNT_MAX    = '1;
  localparam int                RANDOM_ITEMS = 600;
  localparam int                LONG_HOLD    = 400;

  typedef struct packed {
    logic [SLOT_IN_W-1:0] slot_echo;
    logic [RES_W-1:0]     observed_total;
    logic [RES_W-1:0]     occupancy_of_code;
    logic [RES_W-1:0]     transition_total;
    logic [RES_W-1:0]     pair_count;
    logic                 transition_seen;
    logic [CODE_W-1:0]    dominant_code;
    logic                 saturated;
  } slot_report_t;

  typedef struct {
    logic [SLOT_IN_W-1:0] slot;
    logic [CODE_W-1:0]    code;
    bit                   typed;
    slot_report_t         want;
  } stim_row_t;

  localparam slot_report_t NO_REPORT = '0;

  logic clk = 1'b0;
  logic rst_n;

  sth_in_if  in_ch();
  sth_out_if out_ch();

  state_transition_histogram uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Model state of every slot.
  logic [CODE_W-1:0] last_code [SLOT_COUNT];
  logic [RES_W-1:0]  occ_cnt   [SLOT_COUNT][NUM_CODES];
  logic [RES_W-1:0]  obs_cnt   [SLOT_COUNT];
  logic [RES_W-1:0]  trans_cnt [SLOT_COUNT];
  logic [RES_W-1:0]  pair_cnt  [SLOT_COUNT][NUM_CODES][NUM_CODES];

  slot_report_t expected_reports[$];
  int           mismatch_count = 0;
  bit           idle_off       = 1'b0;
  int           hold_request   = 0;

  // Rows with a typed expectation are checked against that value; the model
  // still absorbs them so that later rows stay in step.
  stim_row_t directed_rows [21] = '{
    '{8'd0,   4'd0,         1'b1, '{8'd0, 32'd1, 32'd1, 32'd0, 32'd0, 1'b0, 4'd0, 1'b0}},
    '{8'd0,   4'd7,         1'b1, '{8'd0, 32'd2, 32'd1, 32'd1, 32'd1, 1'b1, 4'd0, 1'b0}},
    '{8'd0,   4'd7,         1'b0, NO_REPORT},
    '{8'd0,   CODE_UNOBS,   1'b0, NO_REPORT},
    '{8'd0,   4'd0,         1'b0, NO_REPORT},
    '{8'd0,   CODE_RAW_TOP, 1'b0, NO_REPORT},
    '{8'd255, CODE_UNOBS,   1'b1, '{8'd255, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, CODE_UNOBS, 1'b0}},
    '{8'd255, CODE_RAW_TOP, 1'b1, '{8'd255, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, CODE_UNOBS, 1'b0}},
    '{8'd255, 4'd5,         1'b1, '{8'd255, 32'd1, 32'd1, 32'd0, 32'd0, 1'b0, 4'd5, 1'b0}},
    '{8'd255, 4'd0,         1'b0, NO_REPORT},
    '{8'd255, 4'd5,         1'b0, NO_REPORT},
    '{8'd255, 4'd0,         1'b0, NO_REPORT},
    '{8'd128, 4'd1,         1'b0, NO_REPORT},
    '{8'd128, 4'd2,         1'b0, NO_REPORT},
    '{8'd128, 4'd3,         1'b0, NO_REPORT},
    '{8'd128, 4'd4,         1'b0, NO_REPORT},
    '{8'd128, 4'd6,         1'b0, NO_REPORT},
    '{8'd128, 4'd9,         1'b0, NO_REPORT},
    '{8'd128, 4'd6,         1'b0, NO_REPORT},
    '{8'd127, 4'd2,         1'b0, NO_REPORT},
    '{8'd1,   4'd12,        1'b1, '{8'd1, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, CODE_UNOBS, 1'b0}}
  };

  // Saturating increment; returns 1 when the counter was already full.
  function automatic logic bump(inout logic [RES_W-1:0] cnt);
    if (cnt == COUNT_MAX) return 1'b1;
    cnt = cnt + RES_W'(1);
    return 1'b0;
  endfunction

  function automatic slot_report_t histogram_update(input logic [SLOT_IN_W-1:0] s,
                                                    input logic [CODE_W-1:0]    c);
    slot_report_t      r;
    logic [CODE_W-1:0] p;
    logic [RES_W-1:0]  best;
    r = '0;
    r.slot_echo = s;
    p = last_code[s];
    if (c < CODE_UNOBS) begin
      r.saturated = bump(occ_cnt[s][c[2:0]]);
      r.saturated |= bump(obs_cnt[s]);
      r.occupancy_of_code = occ_cnt[s][c[2:0]];
      // A transition needs a valid previous code that differs from this one.
      if (p < CODE_UNOBS && p != c) begin
        r.transition_seen = 1'b1;
        r.saturated |= bump(trans_cnt[s]);
        r.saturated |= bump(pair_cnt[s][p[2:0]][c[2:0]]);
        r.pair_count = pair_cnt[s][p[2:0]][c[2:0]];
      end
      last_code[s] = c;
    end else begin
      last_code[s] = CODE_UNOBS;
    end
    r.observed_total   = obs_cnt[s];
    r.transition_total = trans_cnt[s];
    r.dominant_code    = CODE_UNOBS;
    best = '0;
    for (int k = 0; k < NUM_CODES; k++) begin
      if (occ_cnt[s][k] > best) begin
        best = occ_cnt[s][k];
        r.dominant_code = CODE_W'(k);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string field, input logic [SLOT_IN_W-1:0] slot,
                             input logic [RES_W-1:0] got, input logic [RES_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("slot %0d %s = %0d, expected %0d", slot, field, got, want));
  endtask

  task automatic send_observation(input logic [SLOT_IN_W-1:0] s, input logic [CODE_W-1:0] c,
                                  input bit typed, input slot_report_t want);
    int           gap;
    slot_report_t predicted;
    gap = idle_off ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.slot_index <= s;
    in_ch.state_code <= c;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = histogram_update(s, c);
    expected_reports.insert(expected_reports.size(), typed ? want : predicted);
  endtask

  initial begin : stimulus
    logic [SLOT_IN_W-1:0] busy_slot [4];
    logic [SLOT_IN_W-1:0] s;
    logic [CODE_W-1:0]    c;
    int                   pick;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.slot_index = '0;
    in_ch.state_code = '0;
    out_ch.ready     = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      last_code[i] = CODE_UNOBS;
      obs_cnt[i]   = '0;
      trans_cnt[i] = '0;
      for (int a = 0; a < NUM_CODES; a++) begin
        occ_cnt[i][a] = '0;
        for (int b = 0; b < NUM_CODES; b++) pair_cnt[i][a][b] = '0;
      end
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_observation(directed_rows[i].slot, directed_rows[i].code,
                       directed_rows[i].typed, directed_rows[i].want);

    // Random streams: most traffic revisits a few busy slots so that counters
    // grow and back-to-back updates of one slot are frequent.
    for (int chunk = 0; chunk < RANDOM_ITEMS / 100; chunk++) begin
      foreach (busy_slot[k]) busy_slot[k] = SLOT_IN_W'($urandom_range(0, SLOT_COUNT - 1));
      idle_off = (chunk == 2);
      if (chunk == 4) hold_request = LONG_HOLD;
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 99) < 70) s = busy_slot[$urandom_range(0, 3)];
        else s = SLOT_IN_W'($urandom_range(0, SLOT_COUNT - 1));
        pick = $urandom_range(0, 99);
        if (pick < 10) c = CODE_W'($urandom_range(CODE_UNOBS, CODE_RAW_TOP));
        else if (pick < 40 && last_code[s] < CODE_UNOBS) c = last_code[s];
        else c = CODE_W'($urandom_range(0, NUM_CODES - 1));
        send_observation(s, c, 1'b0, NO_REPORT);
      end
    end
    idle_off = 1'b0;
    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (expected_reports.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : result_sink
    slot_report_t got;
    slot_report_t want;
    int           stall;
    @(posedge rst_n);
    forever begin
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else begin
        stall = idle_off ? 0 : $urandom_range(0, 8);
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got = '{out_ch.slot_echo, out_ch.observed_total, out_ch.occupancy_of_code,
              out_ch.transition_total, out_ch.pair_count, out_ch.transition_seen,
              out_ch.dominant_code, out_ch.saturated};
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("result transaction for slot %0d with none pending",
                                  got.slot_echo));
      end else begin
        want = expected_reports.pop_front();
        check_field("slot_echo", want.slot_echo, RES_W'(got.slot_echo),
                    RES_W'(want.slot_echo));
        check_field("observed_total", want.slot_echo, got.observed_total,
                    want.observed_total);
        check_field("occupancy_of_code", want.slot_echo, got.occupancy_of_code,
                    want.occupancy_of_code);
        check_field("transition_total", want.slot_echo, got.transition_total,
                    want.transition_total);
        check_field("pair_count", want.slot_echo, got.pair_count, want.pair_count);
        check_field("transition_seen", want.slot_echo, RES_W'(got.transition_seen),
                    RES_W'(want.transition_seen));
        check_field("dominant_code", want.slot_echo, RES_W'(got.dominant_code),
                    RES_W'(want.dominant_code));
        check_field("saturated", want.slot_echo, RES_W'(got.saturated),
                    RES_W'(want.saturated));
      end
    end
  end

  // The clearing pass alone takes about 131 us; a correct run ends well
  // inside a millisecond.
  initial begin : watchdog
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
